// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the rotation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- src/irra_pkg.sv -----
// Shared types and constants of the right-angle image rotator.
`timescale 1ns / 1ps
`default_nettype none
package irra_pkg;

    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int DIM_W     = 7;
    localparam int ROT_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = DIM_W;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    // rotation register codes; the unused code behaves as 90 degrees
    localparam logic [ROT_W-1:0] ROT_90  = 2'd0;
    localparam logic [ROT_W-1:0] ROT_180 = 2'd1;
    localparam logic [ROT_W-1:0] ROT_270 = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd2;

    typedef struct packed {
        logic wr;
        logic rd;
        logic last;
    } t_mem_req;

endpackage
`default_nettype wire

// ----- src/image_rotate_right_angle.sv -----
// Top level of the 90/180/270 degree clockwise RGB frame rotator.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+--------------------------------------
//  s_axis   | in  | tvalid / tready        | tuser: command; tdata: red, green, blue
//  m_axis   | out | tvalid / tready        | tdata: red, green, blue; tlast: last
//  cfg      | in  | i_cfg_valid/o_cfg_ready| index, data (always accepted)
//
// One beat per clock is accepted while tready is high; read data passes a read stage.
// The rate is set by the single frame-memory port: one write or one read per cycle.
// Synchronous active-low reset clears counters and control registers, not data or memory.
// A stalled output holds one pixel in the output register and one in the read stage;
// input is refused only when both are full and the output is not taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module image_rotate_right_angle #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    input  wire logic [irra_pkg::PIX_W-1:0]       s_axis_tdata,  // red_in, green_in, blue_in
    input  wire logic                             s_axis_tuser,  // command
    output      logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output      logic [irra_pkg::PIX_W-1:0]       m_axis_tdata,  // red_out, green_out, blue_out
    output      logic                             m_axis_tlast,
    input  wire logic                             i_cfg_valid,
    output      logic                             o_cfg_ready,
    input  wire logic [irra_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [irra_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                       acc;
    logic                       cfg_wr;
    irra_pkg::t_mem_req         req;
    logic [AW-1:0]              addr;
    logic [irra_pkg::PIX_W-1:0] ram_q;
    logic                       s1_move;

    logic                       r_s1_valid, n_s1_valid;
    logic                       r_s1_last;
    logic                       r_out_valid, n_out_valid;
    logic [irra_pkg::PIX_W-1:0] r_out_data;
    logic                       r_out_last;

    assign o_cfg_ready = 1'b1;
    // writes beyond the register list change nothing, counters included
    assign cfg_wr = i_cfg_valid & o_cfg_ready &
                    ((i_cfg_index == irra_pkg::REG_ROTATION) ||
                     (i_cfg_index == irra_pkg::REG_WIDTH) ||
                     (i_cfg_index == irra_pkg::REG_HEIGHT));

    assign s1_move       = r_s1_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_s1_valid | ~r_out_valid | m_axis_tready;
    assign acc           = s_axis_tvalid & s_axis_tready;

    irra_addr_gen #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_addr_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_wr),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (acc),
        .i_cmd       (s_axis_tuser),
        .o_req       (req),
        .o_addr      (addr)
    );

    irra_ram #(
        .DATA_W (irra_pkg::PIX_W),
        .DEPTH  (DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (req.wr),
        .i_re    (req.rd),
        .i_addr  (addr),
        .i_wdata (s_axis_tdata),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (req.rd) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_move) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload: hold until the stage advances
    always_ff @(posedge i_clk) begin
        if (req.rd) begin
            r_s1_last <= req.last;
        end
        if (s1_move) begin
            r_out_data <= ram_q;
            r_out_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    `ASSERT_CLK(a_no_overrun,
        (r_s1_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready,
        "input taken while both result stages are blocked")
    `ASSERT_CLK(a_read_fills_stage,
        (acc && s_axis_tuser == irra_pkg::CMD_READ) |=> r_s1_valid,
        "read beat did not reach the read stage")
    `ASSERT_CLK(a_write_no_result,
        (acc && s_axis_tuser == irra_pkg::CMD_WRITE) |=> !r_s1_valid,
        "write beat left a pending result")

endmodule
`default_nettype wire

// ----- src/irra_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module irra_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 4096
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic                                    i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [DATA_W-1:0]                       i_wdata,
    output      logic [DATA_W-1:0]                       o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- src/irra_addr_gen.sv -----
// Configuration registers, load/emit position counters and frame address.
`timescale 1ns / 1ps
`default_nettype none
module irra_addr_gen #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    input  wire logic [irra_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [irra_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                               i_acc,
    input  wire logic                               i_cmd,
    output      irra_pkg::t_mem_req                 o_req,
    output      logic [((MAX_WIDTH * MAX_HEIGHT > 1) ?
                        $clog2(MAX_WIDTH * MAX_HEIGHT) : 1)-1:0] o_addr
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MAX_D  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CTR_W  = (MAX_D > 1) ? $clog2(MAX_D) : 1;
    localparam int LW     = ((CTR_W > irra_pkg::DIM_W) ? CTR_W : irra_pkg::DIM_W) + 1;

    logic [irra_pkg::ROT_W-1:0] r_rot;
    logic [irra_pkg::DIM_W-1:0] r_width, r_height;
    logic [CTR_W-1:0] r_load_col, r_load_row, r_emit_col, r_emit_row;
    logic [CTR_W-1:0] n_load_col, n_load_row, n_emit_col, n_emit_row;

    logic [irra_pkg::DIM_W-1:0] w, h, ow, oh;
    logic [LW-1:0] lc1, lr1, ec1, er1, x, y;
    logic          lc_wrap, lr_wrap, ec_wrap, er_wrap;
    logic          is_rd;

    // zero acts as one, oversize acts as the maximum
    always_comb begin
        if (r_width == '0) begin
            w = irra_pkg::DIM_W'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w = irra_pkg::DIM_W'(MAX_WIDTH);
        end else begin
            w = r_width;
        end
        if (r_height == '0) begin
            h = irra_pkg::DIM_W'(1);
        end else if (32'(r_height) > MAX_HEIGHT) begin
            h = irra_pkg::DIM_W'(MAX_HEIGHT);
        end else begin
            h = r_height;
        end
    end

    // output frame is transposed except at 180 degrees
    assign ow = (r_rot == irra_pkg::ROT_180) ? w : h;
    assign oh = (r_rot == irra_pkg::ROT_180) ? h : w;

    assign lc1 = LW'(r_load_col) + LW'(1);
    assign lr1 = LW'(r_load_row) + LW'(1);
    assign ec1 = LW'(r_emit_col) + LW'(1);
    assign er1 = LW'(r_emit_row) + LW'(1);
    assign lc_wrap = lc1 >= LW'(w);
    assign lr_wrap = lr1 >= LW'(h);
    assign ec_wrap = ec1 >= LW'(ow);
    assign er_wrap = er1 >= LW'(oh);

    // source pixel of the current output position
    always_comb begin
        unique case (r_rot)
            irra_pkg::ROT_180: begin
                x = LW'(w) - ec1;
                y = LW'(h) - er1;
            end
            irra_pkg::ROT_270: begin
                x = LW'(w) - er1;
                y = LW'(r_emit_col);
            end
            default: begin
                x = LW'(r_emit_row);
                y = LW'(h) - ec1;
            end
        endcase
    end

    assign is_rd = (i_cmd == irra_pkg::CMD_READ);

    always_comb begin
        if (is_rd) begin
            o_addr = AW'(y) * AW'(MAX_WIDTH) + AW'(x);
        end else begin
            o_addr = AW'(r_load_row) * AW'(MAX_WIDTH) + AW'(r_load_col);
        end
    end

    assign o_req.wr   = i_acc & ~is_rd;
    assign o_req.rd   = i_acc & is_rd;
    assign o_req.last = ec_wrap & er_wrap;

    always_comb begin
        n_load_col = r_load_col;
        n_load_row = r_load_row;
        n_emit_col = r_emit_col;
        n_emit_row = r_emit_row;
        if (i_cfg_valid) begin
            n_load_col = '0;
            n_load_row = '0;
            n_emit_col = '0;
            n_emit_row = '0;
        end else if (o_req.wr) begin
            n_load_col = lc_wrap ? '0 : CTR_W'(lc1);
            if (lc_wrap) begin
                n_load_row = lr_wrap ? '0 : CTR_W'(lr1);
            end
        end else if (o_req.rd) begin
            n_emit_col = ec_wrap ? '0 : CTR_W'(ec1);
            if (ec_wrap) begin
                n_emit_row = er_wrap ? '0 : CTR_W'(er1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot      <= irra_pkg::ROT_90;
            r_width    <= irra_pkg::DIM_RESET;
            r_height   <= irra_pkg::DIM_RESET;
            r_load_col <= '0;
            r_load_row <= '0;
            r_emit_col <= '0;
            r_emit_row <= '0;
        end else begin
            r_load_col <= n_load_col;
            r_load_row <= n_load_row;
            r_emit_col <= n_emit_col;
            r_emit_row <= n_emit_row;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    irra_pkg::REG_ROTATION: r_rot    <= i_cfg_data[irra_pkg::ROT_W-1:0];
                    irra_pkg::REG_WIDTH:    r_width  <= i_cfg_data;
                    irra_pkg::REG_HEIGHT:   r_height <= i_cfg_data;
                    default: begin
                        // index beyond the register list: drop the write
                        r_rot <= r_rot;
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire
